// ===== hw/rtl/bmj_pkg.sv =====
// ----------------------------------------------------------------------------
// bmj_pkg
// shared constants, types and the control state encoding for the bigram
// multiset jaccard block
// ----------------------------------------------------------------------------
package bmj_pkg;

   // alphabet and bigram table
   localparam int unsigned ALPHA   = 26;
   localparam int unsigned BINS    = ALPHA * ALPHA;
   localparam int unsigned BIN_W   = $clog2(BINS);
   localparam int unsigned LETTER_W = $clog2(ALPHA);

   // per-bin counts, one word holds both strings
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned WORD_W  = 2 * COUNT_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // sums over all bins and the scaled ratio
   localparam int unsigned SUM_W  = COUNT_W + $clog2(BINS);
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned SIM_W  = FRAC_W + 1;
   localparam logic [SIM_W-1:0] SCALE = SIM_W'(1) << FRAC_W;

   // character codes
   localparam int unsigned CHAR_W = 8;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;

   // stream payload widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = CHAR_W;
   localparam int unsigned RSP_DATA_W = ((SIM_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_WALK,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== hw/rtl/bmj_hist_ram.sv =====
// ----------------------------------------------------------------------------
// bmj_hist_ram
// single-port histogram memory, one word per bigram holding both counts,
// read-first with registered read data
// ----------------------------------------------------------------------------
module bmj_hist_ram (
   input  logic                          clock,
   input  logic                          we,
   input  logic [bmj_pkg::BIN_W-1:0]     addr,
   input  logic [bmj_pkg::WORD_W-1:0]    wdata,
   output logic [bmj_pkg::WORD_W-1:0]    rdata
);

   logic [bmj_pkg::WORD_W-1:0] mem [bmj_pkg::BINS];
   logic [bmj_pkg::WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/bmj_div.sv =====
// ----------------------------------------------------------------------------
// bmj_div
// restoring divider, one quotient bit per cycle, gives
// floor(dividend * 2^16 / divisor) for dividend <= divisor
// ----------------------------------------------------------------------------
module bmj_div (
   input  logic                          clock,
   input  logic                          reset,
   input  bmj_pkg::div_req_type          div_req,
   output logic                          busy,
   output logic [bmj_pkg::SIM_W-1:0]     quotient
);

   localparam int unsigned STEP_W = $clog2(bmj_pkg::SIM_W);

   logic                          busy_ff;
   logic [bmj_pkg::SUM_W:0]       rem_ff;
   logic [bmj_pkg::SUM_W-1:0]     divisor_ff;
   logic [bmj_pkg::SIM_W-1:0]     quo_ff;
   logic [STEP_W-1:0]             step_ff;

   logic                          take;
   logic [bmj_pkg::SUM_W:0]       rem_next;

   always_comb begin
      take     = rem_ff >= {1'b0, divisor_ff};
      rem_next = take ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (div_req.start) begin
         busy_ff <= (div_req.divisor != '0);
      end else if (busy_ff && (step_ff == '0)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= {1'b0, div_req.dividend};
         divisor_ff <= div_req.divisor;
         step_ff    <= STEP_W'(bmj_pkg::SIM_W - 1);
         // empty union reads as full similarity
         quo_ff     <= (div_req.divisor == '0) ? bmj_pkg::SCALE : '0;
      end else if (busy_ff) begin
         quo_ff  <= {quo_ff[bmj_pkg::SIM_W-2:0], take};
         rem_ff  <= {rem_next[bmj_pkg::SUM_W-1:0], 1'b0};
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/bigram_multiset_jaccard.sv =====
// ----------------------------------------------------------------------------
// bigram_multiset_jaccard
// character-bigram multiset jaccard similarity of two byte strings, with
// both histograms kept in one single-port memory
// ----------------------------------------------------------------------------
//
// channel   dir   tdata                     tuser           tlast
// req_      in    char_code[7:0]            second_string   string_end
// rsp_      out   similarity[16:0], zeros   -               -
//
// a bigram byte is read at accept, then its count is written back in ST_RMW,
// when no byte is taken; the second string's end adds a walk zeroing every bin,
// a divider load, the divider run and an output state before the next request
// after reset a zero sweep of the memory runs before the first request
// a waiting result stays in the output register while new bytes are taken;
// only a second result stalls until the first one is gone
//
module bigram_multiset_jaccard (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bmj_pkg::REQ_DATA_W-1:0]      req_tdata,   // char_code[7:0]
   input  logic                                req_tuser,   // second_string
   input  logic                                req_tlast,   // string_end
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bmj_pkg::RSP_DATA_W-1:0]      rsp_tdata    // similarity[16:0], zero pad
);

   // control state
   bmj_pkg::state_type                 state_ff, state_in;
   logic [bmj_pkg::BIN_W-1:0]          cnt_ff, cnt_in;
   logic                               rd_valid_ff, rd_valid_in;

   // pairing state and the request in flight
   logic [bmj_pkg::LETTER_W-1:0]       prev_letter_ff;
   logic                               prev_valid_ff;
   logic [bmj_pkg::BIN_W-1:0]          bin_ff;
   logic                               sel_ff;
   logic                               fin_ff;

   // walk sums
   logic [bmj_pkg::SUM_W-1:0]          inter_ff;
   logic [bmj_pkg::SUM_W-1:0]          union_ff;

   // output register
   logic                               rsp_valid_ff;
   logic [bmj_pkg::SIM_W-1:0]          rsp_data_ff;

   // memory port
   logic                               ram_we;
   logic [bmj_pkg::BIN_W-1:0]          ram_addr;
   logic [bmj_pkg::WORD_W-1:0]         ram_wdata;
   logic [bmj_pkg::WORD_W-1:0]         ram_rdata;

   // divider
   bmj_pkg::div_req_type               div_req;
   logic                               div_busy;
   logic [bmj_pkg::SIM_W-1:0]          div_quotient;

   // request decode
   logic                               req_accept;
   logic                               is_upper, is_lower, is_letter;
   logic [bmj_pkg::LETTER_W-1:0]       letter;
   logic                               bigram;
   logic                               fin;
   logic [bmj_pkg::BIN_W-1:0]          bin;
   logic                               load_rsp;

   // read-modify-write and walk datapath
   logic [bmj_pkg::COUNT_W-1:0]        cnt_first, cnt_second, cnt_pick, cnt_bumped;
   logic [bmj_pkg::COUNT_W-1:0]        bin_min, bin_max;

   assign req_accept = req_tvalid && req_tready;

   // case folding
   always_comb begin
      is_upper  = (req_tdata >= bmj_pkg::CHAR_UPPER_A) && (req_tdata <= bmj_pkg::CHAR_UPPER_Z);
      is_lower  = (req_tdata >= bmj_pkg::CHAR_LOWER_A) && (req_tdata <= bmj_pkg::CHAR_LOWER_Z);
      is_letter = is_upper || is_lower;
      letter    = is_upper ? bmj_pkg::LETTER_W'(req_tdata - bmj_pkg::CHAR_UPPER_A)
                           : bmj_pkg::LETTER_W'(req_tdata - bmj_pkg::CHAR_LOWER_A);
      bigram    = is_letter && prev_valid_ff;
      fin       = req_tlast && req_tuser;
      bin       = bmj_pkg::BIN_W'(prev_letter_ff) * bmj_pkg::BIN_W'(bmj_pkg::ALPHA)
                + bmj_pkg::BIN_W'(letter);
   end

   // saturating count bump and per-bin min / max
   always_comb begin
      cnt_first  = ram_rdata[bmj_pkg::COUNT_W-1:0];
      cnt_second = ram_rdata[bmj_pkg::WORD_W-1:bmj_pkg::COUNT_W];
      cnt_pick   = sel_ff ? cnt_second : cnt_first;
      cnt_bumped = (cnt_pick == bmj_pkg::COUNT_MAX) ? cnt_pick
                                                    : cnt_pick + bmj_pkg::COUNT_W'(1);
      bin_min    = (cnt_first < cnt_second) ? cnt_first : cnt_second;
      bin_max    = (cnt_first < cnt_second) ? cnt_second : cnt_first;
   end

   bmj_hist_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   bmj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bmj_pkg::ST_CLEAR;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // next state and memory port control
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      rd_valid_in       = 1'b0;
      req_tready        = 1'b0;
      ram_we            = 1'b0;
      ram_addr          = cnt_ff;
      ram_wdata         = '0;
      load_rsp          = 1'b0;
      div_req.start     = 1'b0;
      div_req.dividend  = inter_ff;
      div_req.divisor   = union_ff;

      unique case (state_ff)
         bmj_pkg::ST_CLEAR: begin
            // zero sweep after reset
            ram_we = 1'b1;
            if (cnt_ff == bmj_pkg::BIN_W'(bmj_pkg::BINS - 1)) begin
               cnt_in   = '0;
               state_in = bmj_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + bmj_pkg::BIN_W'(1);
            end
         end
         bmj_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_addr   = bin;
            if (req_accept) begin
               if (bigram) begin
                  state_in = bmj_pkg::ST_RMW;
               end else if (fin) begin
                  state_in = bmj_pkg::ST_WALK;
               end
            end
         end
         bmj_pkg::ST_RMW: begin
            // count comes back from the read issued at accept
            ram_we    = 1'b1;
            ram_addr  = bin_ff;
            ram_wdata = sel_ff ? {cnt_bumped, cnt_first} : {cnt_second, cnt_bumped};
            state_in  = fin_ff ? bmj_pkg::ST_WALK : bmj_pkg::ST_IDLE;
         end
         bmj_pkg::ST_WALK: begin
            // read each bin and zero it in the same cycle (read-first)
            if (cnt_ff != bmj_pkg::BIN_W'(bmj_pkg::BINS)) begin
               ram_we      = 1'b1;
               rd_valid_in = 1'b1;
               cnt_in      = cnt_ff + bmj_pkg::BIN_W'(1);
            end else begin
               cnt_in   = '0;
               state_in = bmj_pkg::ST_DIV_LOAD;
            end
         end
         bmj_pkg::ST_DIV_LOAD: begin
            div_req.start = 1'b1;
            state_in      = bmj_pkg::ST_DIV_WAIT;
         end
         bmj_pkg::ST_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = bmj_pkg::ST_OUT;
            end
         end
         bmj_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = bmj_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmj_pkg::ST_IDLE;
         end
      endcase
   end

   // pairing state, updated on every accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_letter_ff <= '0;
         prev_valid_ff  <= 1'b0;
      end else if (req_accept) begin
         prev_valid_ff <= is_letter && !req_tlast;
         if (fin) begin
            prev_letter_ff <= '0;
         end else if (is_letter) begin
            prev_letter_ff <= letter;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         bin_ff <= bin;
         sel_ff <= req_tuser;
         fin_ff <= fin;
      end
   end

   // intersection and union sums, one bin per cycle during the walk
   always_ff @(posedge clock) begin
      if (reset || (state_ff == bmj_pkg::ST_IDLE)) begin
         inter_ff <= '0;
         union_ff <= '0;
      end else if (rd_valid_ff) begin
         inter_ff <= inter_ff + bmj_pkg::SUM_W'(bin_min);
         union_ff <= union_ff + bmj_pkg::SUM_W'(bin_max);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= div_quotient;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bmj_pkg::RSP_DATA_W'(rsp_data_ff);

`ifndef ASSERT_OFF
   // a result only appears out of the output-load state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == bmj_pkg::ST_OUT))
      else $error("result raised outside output load");

   // a bigram request writes back the bin that was read at accept
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && bigram) |=> (ram_we && (ram_addr == $past(bin))))
      else $error("count write-back went to the wrong bin");

   // the intersection sum never outgrows the union sum
   assert property (@(posedge clock) disable iff (reset)
      inter_ff <= union_ff)
      else $error("intersection sum exceeds union sum");

   // the ratio is never above one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[bmj_pkg::SIM_W-1:0] <= bmj_pkg::SCALE))
      else $error("similarity above full scale");
`endif

endmodule
